>>> design/cdg_graphics_decoder_unit_assert.svh
// Assertion macros for the CD+G graphics decoder.
// No dependencies.
`ifndef CDG_GRAPHICS_DECODER_UNIT_ASSERT_SVH
`define CDG_GRAPHICS_DECODER_UNIT_ASSERT_SVH
// implication checked every clock, off during reset
`define CDG_ASSERT_IMP(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("cdg check failed");
// next-cycle implication
`define CDG_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("cdg check failed");
`endif

>>> design/cdg_pkg.sv
// Shared types and constants of the CD+G graphics decoder.
// No dependencies.
`default_nettype none
package cdg_pkg;
  localparam logic [5:0] CMD_GRAPHICS   = 6'h09;
  localparam logic [5:0] INS_MEM_PRESET = 6'd1;
  localparam logic [5:0] INS_BORDER     = 6'd2;
  localparam logic [5:0] INS_TILE       = 6'd6;
  localparam logic [5:0] INS_SCROLL_PRE = 6'd20;
  localparam logic [5:0] INS_SCROLL_CPY = 6'd24;
  localparam logic [5:0] INS_PAL_LOW    = 6'd30;
  localparam logic [5:0] INS_PAL_HIGH   = 6'd31;
  localparam logic [5:0] INS_TILE_XOR   = 6'd38;
  localparam logic [1:0] SCR_PLUS  = 2'd1;
  localparam logic [1:0] SCR_MINUS = 2'd2;

  typedef enum logic [10:0] {
    S_CLEAR  = 11'b00000000001,
    S_IDLE   = 11'b00000000010,
    S_FILL   = 11'b00000000100,
    S_TILE_R = 11'b00000001000,
    S_TILE_W = 11'b00000010000,
    S_CPY_R  = 11'b00000100000,
    S_CPY_W  = 11'b00001000000,
    S_SCR_R  = 11'b00010000000,
    S_SCR_W  = 11'b00100000000,
    S_RD     = 11'b01000000000,
    S_RD_W   = 11'b10000000000
  } state_t;
endpackage
`default_nettype wire

>>> design/cdg_graphics_decoder_unit.sv
// CD+G graphics decoder: frame store, scratch store and palette.
// Read: S_RD, then S_RD_W, held while the output stalls. Tile: read then write per pixel.
// Preset: one fill pass. Scroll: copy to scratch, then one remap pass. One item at a time.
// Frame port: one read and one write per cycle; sets the rate.
// Reset: synchronous; a clearing pass (S_CLEAR) zeroes the frame
// before the first item is taken. Uses cdg_pkg and the assert header.
`default_nettype none
`include "cdg_graphics_decoder_unit_assert.svh"
module cdg_graphics_decoder_unit #(
  parameter int SCREEN_W = 300,
  parameter int SCREEN_H = 216,
  parameter int BORDER_W = 6,
  parameter int BORDER_H = 12
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        op,
  input  wire logic [5:0]  command,
  input  wire logic [5:0]  instruction,
  input  wire logic [63:0] data_low,
  input  wire logic [63:0] data_high,
  input  wire logic [8:0]  pixel_x,
  input  wire logic [7:0]  pixel_y,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       red,
  output logic [7:0]       green,
  output logic [7:0]       blue
);
  localparam int NPIX = SCREEN_W * SCREEN_H;
  localparam int AW = $clog2(NPIX);
  localparam int XW = $clog2(SCREEN_W);
  localparam int YW = $clog2(SCREEN_H);
  localparam int DISP_W = SCREEN_W - 2 * BORDER_W;
  localparam int DISP_H = SCREEN_H - 2 * BORDER_H;

  logic [3:0] frame [NPIX];
  logic [3:0] scratch [NPIX];
  logic [11:0] palette [16];
  logic [2:0] fine_h;
  logic [3:0] fine_v;

  cdg_pkg::state_t state;
  logic [XW-1:0] cx;
  logic [YW-1:0] cy;
  logic [AW-1:0] addr;
  logic [127:0] d;
  logic [5:0] ins;
  logic wrap;
  logic [3:0] tx;
  logic [3:0] ty;
  logic [XW-1:0] sx;
  logic [YW-1:0] sy;
  logic border_only;

  logic [3:0] frd;
  logic [3:0] srd;
  logic       fwe;
  logic [AW-1:0] fwa;
  logic [3:0] fwd;
  logic       swe;

  logic [7:0] b [16];
  always_comb begin
    for (int i = 0; i < 16; i++) b[i] = d[8*i +: 8];
  end

  // scroll deltas
  logic signed [XW+1:0] sh;
  logic signed [YW+1:0] sv;
  always_comb begin
    unique case (b[1][5:4])
      cdg_pkg::SCR_PLUS:  sh = (XW+2)'(BORDER_W);
      cdg_pkg::SCR_MINUS: sh = -(XW+2)'(BORDER_W);
      default:            sh = '0;
    endcase
    unique case (b[2][5:4])
      cdg_pkg::SCR_PLUS:  sv = (YW+2)'(BORDER_H);
      cdg_pkg::SCR_MINUS: sv = -(YW+2)'(BORDER_H);
      default:            sv = '0;
    endcase
  end

  // pass position helpers
  logic last_px;
  logic [XW-1:0] cx_next;
  logic [YW-1:0] cy_next;
  always_comb begin
    last_px = (cx == XW'(SCREEN_W - 1)) && (cy == YW'(SCREEN_H - 1));
    if (cx == XW'(SCREEN_W - 1)) begin
      cx_next = '0;
      cy_next = cy + 1'b1;
    end else begin
      cx_next = cx + 1'b1;
      cy_next = cy;
    end
  end

  // source pixel for destination (cx,cy) during scroll: src = dst - shift
  logic signed [XW+1:0] srcx;
  logic signed [YW+1:0] srcy;
  logic src_in;
  logic [XW-1:0] srcx_w;
  logic [YW-1:0] srcy_w;
  always_comb begin
    srcx = $signed({2'b00, cx}) - sh;
    srcy = $signed({2'b00, cy}) - sv;
    src_in = (srcx >= 0) && (srcx < (XW+2)'(SCREEN_W)) &&
             (srcy >= 0) && (srcy < (YW+2)'(SCREEN_H));
    if (srcx < 0) srcx_w = XW'(srcx + (XW+2)'(SCREEN_W));
    else if (srcx >= (XW+2)'(SCREEN_W)) srcx_w = XW'(srcx - (XW+2)'(SCREEN_W));
    else srcx_w = XW'(srcx);
    if (srcy < 0) srcy_w = YW'(srcy + (YW+2)'(SCREEN_H));
    else if (srcy >= (YW+2)'(SCREEN_H)) srcy_w = YW'(srcy - (YW+2)'(SCREEN_H));
    else srcy_w = YW'(srcy);
  end

  function automatic logic [11:0] pal_entry(input logic [7:0] hi, input logic [7:0] lo);
    logic [15:0] c;
    c = {hi, lo};
    return {c[13:10], c[9:8], c[5:4], c[3:0]};
  endfunction

  logic in_border;
  always_comb begin
    in_border = (cy < YW'(BORDER_H)) || (cy >= YW'(SCREEN_H - BORDER_H)) ||
                (cx < XW'(BORDER_W)) || (cx >= XW'(SCREEN_W - BORDER_W));
  end

  logic [AW-1:0] lin;
  assign lin = AW'(cy) * AW'(SCREEN_W) + AW'(cx);

  logic [3:0] tile_col;
  logic tbit;
  assign tbit = b[4'd4 + ty][3'd5 - tx[2:0]];
  assign tile_col = tbit ? b[1][3:0] : b[0][3:0];

  logic [XW-1:0] tpx;
  logic [YW-1:0] tpy;
  assign tpx = sx + XW'(tx);
  assign tpy = sy + YW'(ty);

  logic accept;
  assign in_stall = (state != cdg_pkg::S_IDLE);
  assign accept = in_valid && !in_stall;

  logic [127:0] pkt;
  assign pkt = {data_high, data_low};

  logic [8:0] rx;
  logic [7:0] ry;
  always_comb begin
    rx = (pixel_x > 9'(DISP_W - 1)) ? 9'(DISP_W - 1) : pixel_x;
    ry = (pixel_y > 8'(DISP_H - 1)) ? 8'(DISP_H - 1) : pixel_y;
  end

  logic [AW-1:0] rd_addr_next;
  logic [AW-1:0] waddr;

  // memory ports
  always_ff @(posedge clk) begin
    frd <= frame[rd_addr_next];
    srd <= scratch[rd_addr_next];
    if (fwe) frame[fwa] <= fwd;
    if (swe) scratch[addr] <= frd;
  end

  // tile and remap reads issue their address in the read state so data lands in the write state
  always_comb begin
    fwe = 1'b0;
    fwa = lin;
    fwd = '0;
    swe = 1'b0;
    rd_addr_next = addr;
    unique case (state)
      cdg_pkg::S_CLEAR: begin
        fwe = 1'b1;
      end
      cdg_pkg::S_FILL: begin
        fwe = !border_only || in_border;
        fwd = b[0][3:0];
      end
      cdg_pkg::S_TILE_R: begin
        rd_addr_next = AW'(tpy) * AW'(SCREEN_W) + AW'(tpx);
      end
      cdg_pkg::S_TILE_W: begin
        fwe = 1'b1;
        fwa = waddr;
        fwd = (ins == cdg_pkg::INS_TILE_XOR) ? (frd ^ tile_col) : tile_col;
      end
      cdg_pkg::S_CPY_W: swe = 1'b1;
      cdg_pkg::S_SCR_R: begin
        rd_addr_next = AW'(srcy_w) * AW'(SCREEN_W) + AW'(srcx_w);
      end
      cdg_pkg::S_SCR_W: begin
        fwe = 1'b1;
        fwd = (wrap || src_in) ? srd : b[0][3:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cdg_pkg::S_CLEAR;
      cx <= '0;
      cy <= '0;
      fine_h <= '0;
      fine_v <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < 16; i++) palette[i] <= '0;
    end else begin
      if (out_valid && !out_stall && state != cdg_pkg::S_RD_W) out_valid <= 1'b0;
      unique case (state)
        cdg_pkg::S_CLEAR: begin
          cx <= cx_next;
          cy <= cy_next;
          if (last_px) begin
            cx <= '0;
            cy <= '0;
            state <= cdg_pkg::S_IDLE;
          end
        end
        cdg_pkg::S_IDLE: begin
          if (accept) begin
            d <= {data_high, data_low};
            ins <= instruction;
            cx <= '0;
            cy <= '0;
            tx <= '0;
            ty <= '0;
            if (op) begin
              addr <= AW'(AW'(ry) + AW'(fine_v) + AW'(BORDER_H)) * AW'(SCREEN_W)
                      + AW'(rx) + AW'(fine_h) + AW'(BORDER_W);
              state <= cdg_pkg::S_RD;
            end else if (command == cdg_pkg::CMD_GRAPHICS) begin
              unique case (instruction)
                cdg_pkg::INS_MEM_PRESET, cdg_pkg::INS_BORDER: begin
                  border_only <= (instruction == cdg_pkg::INS_BORDER);
                  state <= cdg_pkg::S_FILL;
                end
                cdg_pkg::INS_TILE, cdg_pkg::INS_TILE_XOR: begin
                  sy <= YW'(data_low[20:16]) * YW'(12);
                  sx <= XW'(data_low[29:24]) * XW'(6);
                  if (data_low[20:16] < 5'(SCREEN_H / 12) &&
                      data_low[29:24] < 6'(SCREEN_W / 6))
                    state <= cdg_pkg::S_TILE_R;
                end
                cdg_pkg::INS_SCROLL_PRE, cdg_pkg::INS_SCROLL_CPY: begin
                  wrap <= (instruction == cdg_pkg::INS_SCROLL_CPY);
                  fine_h <= (data_low[10:8] >= 3'(BORDER_W)) ?
                            3'(BORDER_W - 1) : data_low[10:8];
                  fine_v <= (data_low[19:16] >= 4'(BORDER_H)) ?
                            4'(BORDER_H - 1) : data_low[19:16];
                  if (data_low[13:12] == cdg_pkg::SCR_PLUS ||
                      data_low[13:12] == cdg_pkg::SCR_MINUS ||
                      data_low[21:20] == cdg_pkg::SCR_PLUS ||
                      data_low[21:20] == cdg_pkg::SCR_MINUS) begin
                    addr <= '0;
                    state <= cdg_pkg::S_CPY_R;
                  end
                end
                cdg_pkg::INS_PAL_LOW, cdg_pkg::INS_PAL_HIGH: begin
                  for (int n = 0; n < 8; n++) begin
                    palette[{instruction == cdg_pkg::INS_PAL_HIGH, 3'(n)}] <=
                      pal_entry(pkt[16*n +: 8], pkt[16*n+8 +: 8]);
                  end
                end
                default: ;
              endcase
            end
          end
        end
        cdg_pkg::S_FILL: begin
          cx <= cx_next;
          cy <= cy_next;
          if (last_px) state <= cdg_pkg::S_IDLE;
        end
        cdg_pkg::S_TILE_R: begin
          waddr <= rd_addr_next;
          state <= cdg_pkg::S_TILE_W;
        end
        cdg_pkg::S_TILE_W: begin
          state <= cdg_pkg::S_TILE_R;
          if (tx == 4'd5) begin
            tx <= '0;
            ty <= ty + 1'b1;
            if (ty == 4'd11) state <= cdg_pkg::S_IDLE;
          end else begin
            tx <= tx + 1'b1;
          end
        end
        cdg_pkg::S_CPY_R: state <= cdg_pkg::S_CPY_W;
        cdg_pkg::S_CPY_W: begin
          if (addr == AW'(NPIX - 1)) begin
            cx <= '0;
            cy <= '0;
            state <= cdg_pkg::S_SCR_R;
          end else begin
            addr <= addr + 1'b1;
            state <= cdg_pkg::S_CPY_R;
          end
        end
        cdg_pkg::S_SCR_R: state <= cdg_pkg::S_SCR_W;
        cdg_pkg::S_SCR_W: begin
          cx <= cx_next;
          cy <= cy_next;
          state <= last_px ? cdg_pkg::S_IDLE : cdg_pkg::S_SCR_R;
        end
        cdg_pkg::S_RD: state <= cdg_pkg::S_RD_W;
        cdg_pkg::S_RD_W: begin
          if (!out_valid || !out_stall) begin
            red <= {palette[frd][11:8], 4'h0};
            green <= {palette[frd][7:4], 4'h0};
            blue <= {palette[frd][3:0], 4'h0};
            out_valid <= 1'b1;
            state <= cdg_pkg::S_IDLE;
          end
        end
        default: state <= cdg_pkg::S_IDLE;
      endcase
    end
  end

  `CDG_ASSERT_IMP(a_stall_busy, clk, rst, state != cdg_pkg::S_IDLE, in_stall)
  `CDG_ASSERT_NEXT(a_read_path, clk, rst, accept && op, state == cdg_pkg::S_RD)
  `CDG_ASSERT_IMP(a_fine_h, clk, rst, 1'b1, fine_h < 3'(BORDER_W))
  `CDG_ASSERT_IMP(a_fine_v, clk, rst, 1'b1, fine_v < 4'(BORDER_H))
endmodule
`default_nettype wire

>>> tb/tb_top.sv
// Self-checking testbench for cdg_graphics_decoder_unit: graphics packets and pixel reads
// are checked against an in-bench model of the frame, palette and fine offsets.
// Depends on cdg_pkg and the decoder RTL.
`timescale 1ns / 100ps
module tb_top;
  localparam int SW = 300, SH = 216, BW = 6, BH = 12;
  localparam int NPIX = SW * SH;
  localparam int WATCHDOG = 1000000;
  localparam int HOLD_CYCLES = 400;

  typedef struct {
    bit        op;
    bit [5:0]  command;
    bit [5:0]  instruction;
    bit [63:0] lo;
    bit [63:0] hi;
    bit [8:0]  px;
    bit [7:0]  py;
  } req_t;

  typedef struct {
    bit [7:0] r;
    bit [7:0] g;
    bit [7:0] b;
  } rgb_t;

  logic clk = 0, rst = 1;
  logic in_valid = 0, in_stall, out_valid, out_stall = 0;
  logic op = 0;
  logic [5:0] command = 0, instruction = 0;
  logic [63:0] data_low = 0, data_high = 0;
  logic [8:0] pixel_x = 0;
  logic [7:0] pixel_y = 0;
  logic [7:0] red, green, blue;

  cdg_graphics_decoder_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .op(op), .command(command), .instruction(instruction),
    .data_low(data_low), .data_high(data_high),
    .pixel_x(pixel_x), .pixel_y(pixel_y),
    .out_valid(out_valid), .out_stall(out_stall),
    .red(red), .green(green), .blue(blue)
  );

  always #4 clk = ~clk;

  // model state
  bit [3:0]  frame [NPIX];
  bit [3:0]  scratch [NPIX];
  bit [11:0] pal [16];
  bit [2:0]  fine_h;
  bit [3:0]  fine_v;

  req_t pending [$];
  rgb_t colors_due [$];
  int   n_req_done = 0, n_pix_done = 0, n_scrolls = 0, n_errors = 0;
  int   idle_cycles = 0;
  bit   hold_done = 0;

  function automatic bit [7:0] byte_of(req_t q, int i);
    return (i < 8) ? q.lo[8*i +: 8] : q.hi[8*(i-8) +: 8];
  endfunction

  function automatic void fill(int x0, int y0, int w, int h, bit [3:0] c);
    for (int y = y0; y < y0 + h && y < SH; y++)
      for (int x = x0; x < x0 + w && x < SW; x++)
        frame[y*SW + x] = c;
  endfunction

  function automatic void draw_tile(req_t q, bit xor_mode);
    bit [7:0] b0, b1, rowbits;
    bit [3:0] c;
    int sy, sx;
    b0 = byte_of(q, 0);
    b1 = byte_of(q, 1);
    sy = (byte_of(q, 2) & 8'h1f) * 12;
    sx = (byte_of(q, 3) & 8'h3f) * 6;
    if (sy + 12 > SH || sx + 6 > SW) return;
    for (int y = 0; y < 12; y++)
      for (int x = 0; x < 6; x++) begin
        rowbits = byte_of(q, 4 + y);
        c = rowbits[5 - x] ? b1[3:0] : b0[3:0];
        if (xor_mode) frame[(sy+y)*SW + sx + x] ^= c;
        else frame[(sy+y)*SW + sx + x] = c;
      end
  endfunction

  function automatic void load_colors(req_t q, int base);
    bit [15:0] c;
    for (int n = 0; n < 8; n++) begin
      c = {byte_of(q, 2*n), byte_of(q, 2*n + 1)};
      pal[base + n] = {c[13:10], c[9:8], c[5:4], c[3:0]};
    end
  endfunction

  function automatic int move_of(bit [1:0] code, int step);
    if (code == cdg_pkg::SCR_PLUS) return step;
    if (code == cdg_pkg::SCR_MINUS) return -step;
    return 0;
  endfunction

  function automatic void scroll_frame(req_t q, bit wrap);
    bit [7:0] b0, b1, b2;
    int oh, ov, sh, sv, dx, dy;
    b0 = byte_of(q, 0);
    b1 = byte_of(q, 1);
    b2 = byte_of(q, 2);
    oh = b1[2:0];
    ov = b2[3:0];
    if (oh >= BW) oh = BW - 1;
    if (ov >= BH) ov = BH - 1;
    fine_h = 3'(oh);
    fine_v = 4'(ov);
    sh = move_of(b1[5:4], 6);
    sv = move_of(b2[5:4], 12);
    if (sh == 0 && sv == 0) return;
    n_scrolls++;
    scratch = frame;
    fill(0, 0, SW, SH, b0[3:0]);
    for (int y = 0; y < SH; y++)
      for (int x = 0; x < SW; x++) begin
        dx = x + sh;
        dy = y + sv;
        if (wrap) begin
          dx = (dx + SW) % SW;
          dy = (dy + SH) % SH;
        end else if (dx < 0 || dx >= SW || dy < 0 || dy >= SH) continue;
        frame[dy*SW + dx] = scratch[y*SW + x];
      end
  endfunction

  // update the model for one accepted request; reads queue a color
  function automatic void apply_request(req_t q);
    int px, py;
    bit [11:0] c;
    bit [7:0] b0;
    bit [3:0] fc;
    if (q.op) begin
      px = (q.px > SW - 2*BW - 1) ? SW - 2*BW - 1 : q.px;
      py = (q.py > SH - 2*BH - 1) ? SH - 2*BH - 1 : q.py;
      c = pal[frame[(py + fine_v + BH)*SW + px + fine_h + BW]];
      colors_due.push_back('{{c[11:8], 4'h0}, {c[7:4], 4'h0}, {c[3:0], 4'h0}});
      return;
    end
    if (q.command != cdg_pkg::CMD_GRAPHICS) return;
    b0 = byte_of(q, 0);
    fc = b0[3:0];
    case (q.instruction)
      cdg_pkg::INS_MEM_PRESET: fill(0, 0, SW, SH, fc);
      cdg_pkg::INS_BORDER: begin
        fill(0, 0, SW, BH, fc);
        fill(0, SH - BH, SW, BH, fc);
        fill(0, BH, BW, SH - 2*BH, fc);
        fill(SW - BW, BH, BW, SH - 2*BH, fc);
      end
      cdg_pkg::INS_TILE:       draw_tile(q, 0);
      cdg_pkg::INS_TILE_XOR:   draw_tile(q, 1);
      cdg_pkg::INS_SCROLL_PRE: scroll_frame(q, 0);
      cdg_pkg::INS_SCROLL_CPY: scroll_frame(q, 1);
      cdg_pkg::INS_PAL_LOW:    load_colors(q, 0);
      cdg_pkg::INS_PAL_HIGH:   load_colors(q, 8);
      default: ;
    endcase
  endfunction

  function automatic req_t rand_bits();
    req_t q;
    q.op = 0;
    q.command = cdg_pkg::CMD_GRAPHICS;
    q.instruction = cdg_pkg::INS_TILE;
    q.lo = {$urandom, $urandom};
    q.hi = {$urandom, $urandom};
    q.px = 9'($urandom);
    q.py = 8'($urandom);
    return q;
  endfunction

  function automatic req_t pix_read(int x, int y);
    req_t q;
    q = rand_bits();
    q.op = 1;
    q.command = 6'($urandom);
    q.instruction = 6'($urandom);
    q.px = 9'(x);
    q.py = 8'(y);
    return q;
  endfunction

  function automatic req_t gfx(bit [5:0] ins);
    req_t q;
    q = rand_bits();
    q.instruction = ins;
    return q;
  endfunction

  function automatic req_t tile(bit [5:0] ins, int row, int col);
    req_t q;
    q = gfx(ins);
    q.lo[23:16] = {q.lo[23:21], 5'(row)};
    q.lo[31:24] = {q.lo[31:30], 6'(col)};
    return q;
  endfunction

  function automatic req_t scroll(bit [5:0] ins, bit [1:0] hc, int oh, bit [1:0] vc, int ov);
    req_t q;
    q = gfx(ins);
    q.lo[13:12] = hc;
    q.lo[10:8] = 3'(oh);
    q.lo[21:20] = vc;
    q.lo[19:16] = 4'(ov);
    return q;
  endfunction

  function automatic bit known_ins(bit [5:0] i);
    return i == cdg_pkg::INS_MEM_PRESET || i == cdg_pkg::INS_BORDER ||
           i == cdg_pkg::INS_TILE || i == cdg_pkg::INS_SCROLL_PRE ||
           i == cdg_pkg::INS_SCROLL_CPY || i == cdg_pkg::INS_PAL_LOW ||
           i == cdg_pkg::INS_PAL_HIGH || i == cdg_pkg::INS_TILE_XOR;
  endfunction

  function automatic int draw_gap();
    return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
  endfunction

  // stimulus
  initial begin
    req_t q;
    int k;
    bit [5:0] ins;
    for (int i = 0; i < NPIX; i++) frame[i] = 0;
    for (int i = 0; i < 16; i++) pal[i] = 0;
    fine_h = 0;
    fine_v = 0;

    pending.push_back(pix_read(0, 0));
    pending.push_back(gfx(cdg_pkg::INS_PAL_LOW));
    q = gfx(cdg_pkg::INS_PAL_HIGH);
    q.lo = '1;
    q.hi = '1;
    pending.push_back(q);
    pending.push_back(gfx(cdg_pkg::INS_MEM_PRESET));
    pending.push_back(pix_read(287, 191));
    pending.push_back(gfx(cdg_pkg::INS_BORDER));
    pending.push_back(tile(cdg_pkg::INS_TILE, 0, 0));
    pending.push_back(tile(cdg_pkg::INS_TILE_XOR, 0, 0));
    pending.push_back(tile(cdg_pkg::INS_TILE, 17, 49));
    pending.push_back(tile(cdg_pkg::INS_TILE, 18, 3));   // off screen, dropped
    pending.push_back(tile(cdg_pkg::INS_TILE_XOR, 4, 50));
    pending.push_back(pix_read(0, 0));
    pending.push_back(pix_read(511, 255));      // clamped to the last pixel
    // fine offsets clamp, nothing moves
    pending.push_back(scroll(cdg_pkg::INS_SCROLL_PRE, 2'd3, 7, 2'd0, 15));
    pending.push_back(pix_read(0, 0));
    pending.push_back(scroll(cdg_pkg::INS_SCROLL_PRE, cdg_pkg::SCR_PLUS, 2,
                             cdg_pkg::SCR_MINUS, 3));
    pending.push_back(pix_read(5, 186));
    pending.push_back(scroll(cdg_pkg::INS_SCROLL_CPY, cdg_pkg::SCR_MINUS, 0,
                             cdg_pkg::SCR_PLUS, 0));
    pending.push_back(pix_read(287, 0));
    q = gfx(cdg_pkg::INS_TILE);
    q.command = 6'h19;                          // not a graphics command
    pending.push_back(q);
    pending.push_back(gfx(6'd0));
    pending.push_back(gfx(6'd63));
    pending.push_back(pix_read(100, 100));
    // run of reads that backs up behind the long output hold-off
    for (int n = 0; n < 4; n++)
      pending.push_back(pix_read($urandom_range(0, 287), $urandom_range(0, 191)));

    for (int n = 0; n < 75; n++) begin
      if (n == 20)
        q = scroll(cdg_pkg::INS_SCROLL_CPY, 2'($urandom), $urandom, cdg_pkg::SCR_PLUS,
                   $urandom);
      else if (n == 55)
        q = scroll(cdg_pkg::INS_SCROLL_PRE, cdg_pkg::SCR_MINUS, $urandom, 2'($urandom),
                   $urandom);
      else if (n == 70)
        q = gfx(($urandom & 1) ? cdg_pkg::INS_MEM_PRESET : cdg_pkg::INS_BORDER);
      else begin
        k = $urandom_range(0, 99);
        if (k < 40) q = pix_read($urandom_range(0, 9) == 0 ? $urandom_range(0, 511) :
                                 $urandom_range(0, 287),
                                 $urandom_range(0, 9) == 0 ? $urandom_range(0, 255) :
                                 $urandom_range(0, 191));
        else if (k < 65) q = tile($urandom & 1 ? cdg_pkg::INS_TILE : cdg_pkg::INS_TILE_XOR,
                                  $urandom_range(0, 9) == 0 ? $urandom_range(0, 31) :
                                  $urandom_range(0, 17),
                                  $urandom_range(0, 9) == 0 ? $urandom_range(0, 63) :
                                  $urandom_range(0, 49));
        else if (k < 78)
          q = gfx($urandom & 1 ? cdg_pkg::INS_PAL_LOW : cdg_pkg::INS_PAL_HIGH);
        else if (k < 86) begin
          q = rand_bits();
          q.command = 6'($urandom_range(0, 63));
          if (q.command == cdg_pkg::CMD_GRAPHICS) q.command = 6'h29;
          q.instruction = 6'($urandom);
        end else if (k < 92) begin
          do ins = 6'($urandom); while (known_ins(ins));
          q = gfx(ins);
        end else
          q = scroll($urandom & 1 ? cdg_pkg::INS_SCROLL_PRE : cdg_pkg::INS_SCROLL_CPY,
                     $urandom & 1 ? 2'd0 : 2'd3, $urandom,
                     $urandom & 1 ? 2'd0 : 2'd3, $urandom);
      end
      pending.push_back(q);
    end
  end

  // request driver
  req_t cur;
  int   gap = 0;
  always @(posedge clk) begin
    bit offering;
    if (rst) begin
      in_valid <= 0;
      gap <= draw_gap();
    end else begin
      offering = in_valid;
      if (in_valid && !in_stall) begin
        apply_request(cur);
        n_req_done++;
        offering = 0;
      end
      if (!offering) begin
        if (gap > 0) begin
          gap <= gap - 1;
          in_valid <= 0;
        end else if (pending.size() > 0) begin
          cur = pending.pop_front();
          op <= cur.op;
          command <= cur.command;
          instruction <= cur.instruction;
          data_low <= cur.lo;
          data_high <= cur.hi;
          pixel_x <= cur.px;
          pixel_y <= cur.py;
          in_valid <= 1;
          gap <= draw_gap();
        end else
          in_valid <= 0;
      end
    end
  end

  // result monitor and stall generator
  int stall_left = 0, hold_left = 0;
  always @(posedge clk) begin
    rgb_t e;
    if (rst) out_stall <= 0;
    else begin
      if (out_valid && !out_stall) begin
        n_pix_done++;
        stall_left = draw_gap();
        if (colors_due.size() == 0) begin
          $display("%0t: unexpected pixel %h %h %h", $time, red, green, blue);
          n_errors++;
        end else begin
          e = colors_due.pop_front();
          if (red !== e.r) begin
            $display("%0t: red expected %h actual %h", $time, e.r, red);
            n_errors++;
          end
          if (green !== e.g) begin
            $display("%0t: green expected %h actual %h", $time, e.g, green);
            n_errors++;
          end
          if (blue !== e.b) begin
            $display("%0t: blue expected %h actual %h", $time, e.b, blue);
            n_errors++;
          end
        end
      end
      // one long hold-off during the run of reads so the block backs up into its input
      if (!hold_done && n_pix_done >= 8) begin
        hold_done = 1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1;
      end else
        out_stall <= 0;
    end
  end

  // watchdog: cycles with no request or pixel accepted
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else if (idle_cycles >= WATCHDOG) begin
      $display("%0t: timeout", $time);
      $display("tb_top failed");
      $finish;
    end else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    while (pending.size() > 0 || in_valid || colors_due.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (colors_due.size() > 0) begin
      $display("%0t: %0d pixels never returned", $time, colors_due.size());
      n_errors++;
    end
    $display("Covered %0d requests, %0d pixel reads, %0d moving scrolls; %0d errors",
             n_req_done, n_pix_done, n_scrolls, n_errors);
    if (n_errors == 0) $display("tb_top passed");
    else $display("tb_top failed");
    $finish;
  end
endmodule

>>> files.f
+incdir+design
design/cdg_pkg.sv
design/cdg_graphics_decoder_unit.sv
tb/tb_top.sv
